FILE: sv/kte_pkg.sv
// shared types, constants and helpers of the keyframe track evaluator
`default_nettype none

package kte_pkg;

  // defaults for the top-level parameters
  localparam int MAX_KEYS_DEF  = 64;
  localparam int LANE_BITS_DEF = 32;

  localparam int NUM_LANES = 4;
  localparam int VAL_W     = 32;

  // stream word layout
  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 128;
  localparam int IDX_LSB     = 0;
  localparam int TIME_LSB    = 6;
  localparam int CURVE_LSB   = 38;
  localparam int LANE_LSB    = 41;

  // command codes carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_KIND      = 2'd1;
  localparam logic [1:0] REG_MIN_DUR   = 2'd2;

  // value kinds
  localparam logic [2:0] KIND_BOOL   = 3'd0;
  localparam logic [2:0] KIND_SHORT  = 3'd1;
  localparam logic [2:0] KIND_INT    = 3'd2;
  localparam logic [2:0] KIND_FLOAT  = 3'd3;
  localparam logic [2:0] KIND_COLOUR = 3'd4;
  localparam logic [2:0] KIND_VEC2   = 3'd5;
  localparam logic [2:0] KIND_VEC3   = 3'd6;
  localparam logic [2:0] KIND_VEC4   = 3'd7;

  // curve codes
  localparam logic [2:0] CURVE_STEP     = 3'd0;
  localparam logic [2:0] CURVE_LINEAR   = 3'd1;
  localparam logic [2:0] CURVE_EASE_IN  = 3'd2;
  localparam logic [2:0] CURVE_EASE_OUT = 3'd3;
  localparam logic [2:0] CURVE_IN_OUT   = 3'd4;

  // Q16.16 one
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // one stored key
  typedef struct packed {
    logic [31:0]                      time_pt;
    logic [2:0]                       curve;
    logic [NUM_LANES-1:0][VAL_W-1:0] lanes;
  } key_t;

  // number of lanes a kind keeps
  function automatic logic [2:0] lanes_used(input logic [2:0] kind);
    logic [2:0] n;
    case (kind)
      KIND_COLOUR: n = 3'd4;
      KIND_VEC2:   n = 3'd2;
      KIND_VEC3:   n = 3'd3;
      KIND_VEC4:   n = 3'd4;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/kte_div.sv
// restoring divider for the Q0.16 segment fraction, one quotient bit a cycle
`default_nettype none

module kte_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             busy_o,
  output logic [15:0]      quot_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [33:0] rem_q;
  logic [32:0] den_q;
  logic [15:0] quot_q;
  logic [33:0] shifted;
  logic [33:0] diff;
  logic        ge;

  // trial subtract
  assign shifted = {rem_q[32:0], 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd16;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff : shifted;
      quot_q <= {quot_q[14:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: sv/kte_ease.sv
// two-stage easing of the segment fraction
`default_nettype none

module kte_ease (
  input  wire logic        clk_i,
  input  wire logic [16:0] f_i,
  input  wire logic [2:0]  curve_i,
  output logic [16:0]      e_o
);

  logic [33:0] sq_q;
  logic [33:0] gg_q;
  logic [17:0] w_q;
  logic [16:0] f_q;
  logic [2:0]  c_q;
  logic [16:0] e_q;
  logic [16:0] g;
  logic [51:0] cube;

  assign g = 17'h1_0000 - f_i;

  // stage one: squares and smoothstep weight
  always_ff @(posedge clk_i) begin
    sq_q <= 34'(f_i) * 34'(f_i);
    gg_q <= 34'(g) * 34'(g);
    w_q  <= 18'd196608 - {f_i, 1'b0};
    f_q  <= f_i;
    c_q  <= curve_i;
  end

  assign cube = 52'(sq_q) * 52'(w_q);

  // stage two: pick the curve
  always_ff @(posedge clk_i) begin
    case (c_q)
      kte_pkg::CURVE_EASE_IN:  e_q <= sq_q[32:16];
      kte_pkg::CURVE_EASE_OUT: e_q <= 17'h1_0000 - gg_q[32:16];
      kte_pkg::CURVE_IN_OUT:   e_q <= cube[48:32];
      default:                 e_q <= f_q;
    endcase
  end

  assign e_o = e_q;

endmodule

`default_nettype wire

FILE: sv/kte_lane.sv
// one value lane: a + floor((b - a) * e / 65536)
`default_nettype none

module kte_lane (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [16:0] e_i,
  output logic [31:0]      res_o
);

  logic signed [32:0] d_q;
  logic signed [50:0] prod_q;
  logic signed [34:0] sum;

  // difference, then scaled difference
  always_ff @(posedge clk_i) begin
    d_q    <= $signed({b_i[31], b_i}) - $signed({a_i[31], a_i});
    prod_q <= d_q * $signed({1'b0, e_i});
  end

  // floor shift and add
  assign sum   = $signed({{3{a_i[31]}}, a_i}) + $signed(prod_q[50:16]);
  assign res_o = sum[31:0];

endmodule

`default_nettype wire

FILE: sv/keyframe_track_evaluator.sv
// top level: key store, segment search, divider, easing and lane merge
//
//  channel | direction | handshake                    | payload
//  cfg     | in        | cfg_valid_i / cfg_ready_o    | cfg_addr_i, cfg_data_i
//  s_axis  | in        | s_axis_tvalid / tready       | tuser cmd, tdata key fields
//  m_axis  | out       | m_axis_tvalid / tready       | tdata four lanes
//
// a load is written into key memory when accepted; an evaluate searches the keys
// for the segment holding the query time (one key read a cycle; held keys and the
// empty track finish sooner) and, when interpolating, runs the 16-step divider
// and then the easing and lane pipeline
// reset clears the control state, configuration and sequencer registers and the output word; key memory stays undefined
// s_axis is taken only while the sequencer is idle; a waiting result does not
// block loads, and a finished evaluate waits until the output word is free
`default_nettype none

module keyframe_track_evaluator #(
  parameter int MAX_KEYS  = kte_pkg::MAX_KEYS_DEF,
  parameter int LANE_BITS = kte_pkg::LANE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [1:0]                       cfg_addr_i,
  input  wire logic [16:0]                      cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // key_index, time_point, curve, lane_zero_in .. lane_three_in, zero fill
  input  wire logic [kte_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // cmd
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // lane_zero_out, lane_one_out, lane_two_out, lane_three_out
  output logic [kte_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int IW   = (AW + 1 > 6) ? AW + 1 : 6;
  localparam int CW   = (AW + 1 > 7) ? AW + 1 : 7;
  localparam int KEEP = (LANE_BITS < 32) ? LANE_BITS : 32;
  localparam int SH   = 32 - KEEP;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_CHKLAST, S_SRCH, S_DIV, S_EASE, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    SEL_DEF, SEL_A, SEL_B, SEL_INT
  } sel_e;

  state_e        state_q;
  sel_e          sel_q;
  logic [AW-1:0] addr_q;
  logic [1:0]    wait_q;
  logic [31:0]   q_q;
  kte_pkg::key_t a_q;
  kte_pkg::key_t b_q;
  kte_pkg::key_t rd_q;
  kte_pkg::key_t key_mem [MAX_KEYS];
  kte_pkg::key_t ld_key;
  logic          out_valid_q;
  logic [kte_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic [6:0]  key_count_q;
  logic [2:0]  kind_q;
  logic [16:0] min_dur_q;

  logic          in_fire;
  logic          load_we;
  logic [IW-1:0] slot_w;
  logic [CW-1:0] kc_w;
  logic [CW-1:0] n_w;
  logic [CW-1:0] last_w;
  logic          div_start;
  logic          div_busy;
  logic [15:0]   quot;
  logic [32:0]   dur;
  logic [32:0]   num;
  logic          hit;
  logic          out_load;
  logic [16:0]   ease_e;
  logic [2:0]    used;
  logic [kte_pkg::NUM_LANES-1:0][31:0] lane_res;
  logic [kte_pkg::OUT_TDATA_W-1:0]     merged;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      kind_q      <= kte_pkg::KIND_FLOAT;
      min_dur_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        kte_pkg::REG_KEY_COUNT: key_count_q <= cfg_data_i[6:0];
        kte_pkg::REG_KIND:      kind_q      <= cfg_data_i[2:0];
        kte_pkg::REG_MIN_DUR:   min_dur_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input decode
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_w        = IW'(s_axis_tdata[kte_pkg::IDX_LSB +: 6]);
  assign load_we       = in_fire && (s_axis_tuser == kte_pkg::CMD_LOAD)
                         && (slot_w < IW'(MAX_KEYS));

  always_comb begin
    ld_key.time_pt = s_axis_tdata[kte_pkg::TIME_LSB +: 32];
    ld_key.curve   = s_axis_tdata[kte_pkg::CURVE_LSB +: 3];
    for (int j = 0; j < kte_pkg::NUM_LANES; j++) begin
      ld_key.lanes[j] = 32'($signed(s_axis_tdata[kte_pkg::LANE_LSB + 32*j +: 32] << SH)
                            >>> SH);
    end
  end

  // key memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      key_mem[slot_w[AW-1:0]] <= ld_key;
    end
    rd_q <= key_mem[addr_q];
  end

  // keys in use
  assign kc_w   = CW'(key_count_q);
  assign n_w    = (kc_w > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : kc_w;
  assign last_w = n_w - CW'(1);

  // segment tests on the word just read
  assign hit = $signed(q_q) < $signed(rd_q.time_pt);
  assign dur = $signed({rd_q.time_pt[31], rd_q.time_pt})
               - $signed({a_q.time_pt[31], a_q.time_pt});
  assign num = $signed({q_q[31], q_q}) - $signed({a_q.time_pt[31], a_q.time_pt});
  assign div_start = (state_q == S_SRCH) && hit
                     && ($signed({1'b0, dur}) > $signed({17'b0, min_dur_q}))
                     && (kind_q > kte_pkg::KIND_INT)
                     && (a_q.curve != kte_pkg::CURVE_STEP);

  kte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (dur),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  kte_ease u_ease (
    .clk_i   (clk_i),
    .f_i     ({1'b0, quot}),
    .curve_i (a_q.curve),
    .e_o     (ease_e)
  );

  // interpolation lanes
  for (genvar l = 0; l < kte_pkg::NUM_LANES; l++) begin : g_lane
    kte_lane u_lane (
      .clk_i (clk_i),
      .a_i   (a_q.lanes[l]),
      .b_i   (b_q.lanes[l]),
      .e_i   (ease_e),
      .res_o (lane_res[l])
    );
  end

  // merge the lanes into one result word
  assign used = kte_pkg::lanes_used(kind_q);

  always_comb begin
    for (int j = 0; j < kte_pkg::NUM_LANES; j++) begin
      if (sel_q == SEL_DEF) begin
        merged[32*j +: 32] = (kind_q == kte_pkg::KIND_COLOUR) ? kte_pkg::ONE_Q16 : '0;
      end else if (3'(j) >= used) begin
        merged[32*j +: 32] = '0;
      end else begin
        case (sel_q)
          SEL_A:   merged[32*j +: 32] = a_q.lanes[j];
          SEL_B:   merged[32*j +: 32] = b_q.lanes[j];
          default: merged[32*j +: 32] = lane_res[j];
        endcase
      end
    end
  end

  // a finished evaluate moves into the output word once it is free
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // sequencer and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= SEL_DEF;
      addr_q      <= '0;
      wait_q      <= '0;
      q_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && (s_axis_tuser == kte_pkg::CMD_EVAL)) begin
            q_q    <= s_axis_tdata[kte_pkg::TIME_LSB +: 32];
            addr_q <= '0;
            if (n_w == '0) begin
              sel_q   <= SEL_DEF;
              state_q <= S_OUT;
            end else begin
              state_q <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          addr_q  <= last_w[AW-1:0];
          state_q <= S_LAST;
        end
        S_LAST: begin
          a_q    <= rd_q;
          addr_q <= AW'(1);
          if ($signed(q_q) <= $signed(rd_q.time_pt)) begin
            sel_q   <= SEL_A;
            state_q <= S_OUT;
          end else begin
            state_q <= S_CHKLAST;
          end
        end
        S_CHKLAST: begin
          addr_q <= addr_q + AW'(1);
          if ($signed(q_q) >= $signed(rd_q.time_pt)) begin
            a_q     <= rd_q;
            sel_q   <= SEL_A;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          addr_q <= addr_q + AW'(1);
          if (hit) begin
            b_q <= rd_q;
            if ($signed({1'b0, dur}) <= $signed({17'b0, min_dur_q})) begin
              sel_q   <= SEL_B;
              state_q <= S_OUT;
            end else if (div_start) begin
              sel_q   <= SEL_INT;
              state_q <= S_DIV;
            end else begin
              sel_q   <= SEL_A;
              state_q <= S_OUT;
            end
          end else begin
            a_q <= rd_q;
          end
        end
        S_DIV: begin
          wait_q <= '0;
          if (!div_busy) begin
            state_q <= S_EASE;
          end
        end
        S_EASE: begin
          wait_q <= wait_q + 2'd1;
          if (wait_q == 2'd3) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_q <= merged;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
